// File: rtl/core/fird_pkg.sv
// Shared types, constants and the rounding function of the decimating FIR filter.
package fird_pkg;

	localparam int MAX_TAPS     = 64;
	localparam int SAMPLE_WIDTH = 16;
	localparam int FRAC_BITS    = SAMPLE_WIDTH - 1;
	localparam int ADDR_W       = $clog2(MAX_TAPS);
	localparam int CNT_W        = $clog2(MAX_TAPS + 1);
	localparam int PROD_W       = 2 * SAMPLE_WIDTH;
	localparam int ACC_W        = PROD_W + $clog2(MAX_TAPS) + 1;
	localparam int MAX_DEC      = 16;

	localparam int DEC_W        = 5;
	localparam int TAPS_W       = 7;
	localparam int CFG_DATA_W   = 7;
	localparam int COEF_IDX_W   = 6;

	localparam logic CFG_DECIMATION = 1'b0;
	localparam logic CFG_TAP_COUNT  = 1'b1;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	localparam logic signed [ACC_W-1:0] OUT_MAX =
		ACC_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
	localparam logic signed [ACC_W-1:0] OUT_MIN = -OUT_MAX - 1;
	localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(64'd1 << (FRAC_BITS - 1));

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_ISSUE = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	typedef struct packed {
		logic clear;
		logic vld;
	} mac_ctl_t;

	function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
		input logic signed [ACC_W-1:0] a
	);
		logic signed [ACC_W-1:0] r;
		logic signed [SAMPLE_WIDTH-1:0] y;
		r = a + HALF_LSB;
		r = r >>> FRAC_BITS;
		if (r > OUT_MAX) begin
			y = OUT_MAX[SAMPLE_WIDTH-1:0];
		end else if (r < OUT_MIN) begin
			y = OUT_MIN[SAMPLE_WIDTH-1:0];
		end else begin
			y = r[SAMPLE_WIDTH-1:0];
		end
		return y;
	endfunction

endpackage

// File: rtl/core/fird_store.sv
// Delay-line and coefficient memories with per-entry valid bits cleared at reset.
module fird_store (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     x_we,
	input  logic [fird_pkg::ADDR_W-1:0]              x_waddr,
	input  logic signed [fird_pkg::SAMPLE_WIDTH-1:0] x_wdata,
	input  logic [fird_pkg::ADDR_W-1:0]              x_raddr,
	input  logic                                     c_we,
	input  logic [fird_pkg::ADDR_W-1:0]              c_waddr,
	input  logic signed [fird_pkg::SAMPLE_WIDTH-1:0] c_wdata,
	input  logic [fird_pkg::ADDR_W-1:0]              c_raddr,
	output logic signed [fird_pkg::SAMPLE_WIDTH-1:0] x_rdata,
	output logic signed [fird_pkg::SAMPLE_WIDTH-1:0] c_rdata
);

	logic signed [fird_pkg::SAMPLE_WIDTH-1:0] x_mem [fird_pkg::MAX_TAPS];
	logic signed [fird_pkg::SAMPLE_WIDTH-1:0] c_mem [fird_pkg::MAX_TAPS];
	logic [fird_pkg::MAX_TAPS-1:0]            x_vld_q;
	logic [fird_pkg::MAX_TAPS-1:0]            c_vld_q;
	logic signed [fird_pkg::SAMPLE_WIDTH-1:0] x_rd_q;
	logic signed [fird_pkg::SAMPLE_WIDTH-1:0] c_rd_q;
	logic                                     x_hit_q;
	logic                                     c_hit_q;

	always_ff @(posedge clk) begin
		if (x_we) begin
			x_mem[x_waddr] <= x_wdata;
		end
		if (c_we) begin
			c_mem[c_waddr] <= c_wdata;
		end
		x_rd_q <= x_mem[x_raddr];
		c_rd_q <= c_mem[c_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_vld_q <= '0;
			c_vld_q <= '0;
			x_hit_q <= 1'b0;
			c_hit_q <= 1'b0;
		end else begin
			if (x_we) begin
				x_vld_q[x_waddr] <= 1'b1;
			end
			if (c_we) begin
				c_vld_q[c_waddr] <= 1'b1;
			end
			x_hit_q <= x_vld_q[x_raddr];
			c_hit_q <= c_vld_q[c_raddr];
		end
	end

	assign x_rdata = x_hit_q ? x_rd_q : '0;
	assign c_rdata = c_hit_q ? c_rd_q : '0;

endmodule

// File: rtl/core/fird_mac.sv
// Shared multiply-accumulate unit with rounding and saturation of the sum.
module fird_mac (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  fird_pkg::mac_ctl_t                       ctl,
	input  logic signed [fird_pkg::SAMPLE_WIDTH-1:0] x,
	input  logic signed [fird_pkg::SAMPLE_WIDTH-1:0] h,
	output logic                                     busy,
	output logic signed [fird_pkg::SAMPLE_WIDTH-1:0] result
);

	logic signed [fird_pkg::PROD_W-1:0] prod_s2;
	logic                               prod_vld_s2;
	logic signed [fird_pkg::ACC_W-1:0]  acc_q;
	logic signed [fird_pkg::ACC_W-1:0]  prod_ext;

	assign prod_ext = {{(fird_pkg::ACC_W - fird_pkg::PROD_W){prod_s2[fird_pkg::PROD_W-1]}},
		prod_s2};

	always_ff @(posedge clk) begin
		prod_s2 <= x * h;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s2 <= 1'b0;
			acc_q       <= '0;
		end else begin
			prod_vld_s2 <= ctl.vld & ~ctl.clear;
			if (ctl.clear) begin
				acc_q <= '0;
			end else if (prod_vld_s2) begin
				acc_q <= acc_q + prod_ext;
			end
		end
	end

	assign busy   = prod_vld_s2;
	assign result = fird_pkg::round_sat(acc_q);

endmodule

// File: rtl/core/fir_decimator.sv
// Top level of the decimating FIR filter: sequencer, configuration and output register.
//
// Input channel (in_valid/in_stall) carries one item: a coefficient load
// (command 1, coef_index, coef_value) or a sample push (command 0, sample).
// A load gives no result. A push shifts the sample into
// the delay line; on every decimation-th push (0 acts as 1, above 16 as 16)
// the block computes sum h[k]*x[newest-k] over tap_count taps (at most 64)
// with one shared multiplier and accumulator, one tap per cycle, and emits
// the rounded, saturated Q1.15 value on the output channel (out_valid/out_stall,
// field filtered). A computing push holds in_stall high through the tap reads,
// then multiply, accumulate and result load; the load waits while an earlier
// result is still held by out_stall. Other pushes and loads leave in_stall low.
// The result sits in an output register; a new item is accepted while it
// waits, but the next result is held until the receiver drops out_stall.
// Reset clears delay line, coefficients (through valid bits), phase and
// the registers (decimation 2, tap_count 64). Write configuration through
// cfg_we/cfg_index/cfg_data only while the block is idle.
module fir_decimator (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_we,
	input  logic                                       cfg_index,
	input  logic [fird_pkg::CFG_DATA_W-1:0]            cfg_data,
	input  logic                                       in_valid,
	output logic                                       in_stall,
	input  logic                                       command,
	input  logic signed [fird_pkg::SAMPLE_WIDTH-1:0]   sample,
	input  logic [fird_pkg::COEF_IDX_W-1:0]            coef_index,
	input  logic signed [fird_pkg::SAMPLE_WIDTH-1:0]   coef_value,
	output logic                                       out_valid,
	input  logic                                       out_stall,
	output logic signed [fird_pkg::SAMPLE_WIDTH-1:0]   filtered
);

	fird_pkg::state_t                         state_q;
	logic [fird_pkg::DEC_W-1:0]               dec_q;
	logic [fird_pkg::TAPS_W-1:0]              taps_q;
	logic [3:0]                               phase_q;
	logic [fird_pkg::ADDR_W-1:0]              wp_q;
	logic [fird_pkg::ADDR_W-1:0]              rd_ptr_q;
	logic [fird_pkg::CNT_W-1:0]               k_q;
	logic [fird_pkg::CNT_W-1:0]               taps_run_q;
	logic                                     issue_s1;
	logic                                     out_valid_q;
	logic signed [fird_pkg::SAMPLE_WIDTH-1:0] filtered_q;

	logic                                     accept;
	logic                                     is_load;
	logic                                     fire;
	logic                                     issue;
	logic                                     done;
	logic [fird_pkg::DEC_W-1:0]               dec_eff;
	logic [fird_pkg::CNT_W-1:0]               taps_eff;
	logic [fird_pkg::DEC_W-1:0]               phase_inc;
	logic [fird_pkg::ADDR_W-1:0]              wp_nxt;
	logic                                     c_we;
	logic [fird_pkg::ADDR_W-1:0]              c_raddr;
	logic signed [fird_pkg::SAMPLE_WIDTH-1:0] x_rdata;
	logic signed [fird_pkg::SAMPLE_WIDTH-1:0] c_rdata;
	logic                                     mac_busy;
	logic signed [fird_pkg::SAMPLE_WIDTH-1:0] mac_result;
	fird_pkg::mac_ctl_t                       mac_ctl;

	assign in_stall = (state_q != fird_pkg::ST_IDLE);
	assign accept   = in_valid & ~in_stall;
	assign is_load  = (command == fird_pkg::CMD_LOAD);
	assign issue    = (state_q == fird_pkg::ST_ISSUE);

	always_comb begin
		if (dec_q == '0) begin
			dec_eff = fird_pkg::DEC_W'(1);
		end else if (32'(dec_q) > fird_pkg::MAX_DEC) begin
			dec_eff = fird_pkg::DEC_W'(fird_pkg::MAX_DEC);
		end else begin
			dec_eff = dec_q;
		end
		if (32'(taps_q) > fird_pkg::MAX_TAPS) begin
			taps_eff = fird_pkg::CNT_W'(fird_pkg::MAX_TAPS);
		end else begin
			taps_eff = fird_pkg::CNT_W'(taps_q);
		end
		if (32'(wp_q) == fird_pkg::MAX_TAPS - 1) begin
			wp_nxt = '0;
		end else begin
			wp_nxt = wp_q + 1'b1;
		end
	end

	assign phase_inc = {1'b0, phase_q} + 1'b1;
	assign fire      = accept & ~is_load & ~(phase_inc < dec_eff);
	assign c_we      = accept & is_load & (32'(coef_index) < fird_pkg::MAX_TAPS);
	assign c_raddr   = k_q[fird_pkg::ADDR_W-1:0];
	assign done      = (state_q == fird_pkg::ST_DRAIN) & ~issue_s1 & ~mac_busy
		& (~out_valid_q | ~out_stall);

	assign mac_ctl.clear = fire;
	assign mac_ctl.vld   = issue_s1;

	fird_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.x_we    (accept & ~is_load),
		.x_waddr (wp_nxt),
		.x_wdata (sample),
		.x_raddr (rd_ptr_q),
		.c_we    (c_we),
		.c_waddr (fird_pkg::ADDR_W'(coef_index)),
		.c_wdata (coef_value),
		.c_raddr (c_raddr),
		.x_rdata (x_rdata),
		.c_rdata (c_rdata)
	);

	fird_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.x      (x_rdata),
		.h      (c_rdata),
		.busy   (mac_busy),
		.result (mac_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q  <= fird_pkg::DEC_W'(2);
			taps_q <= fird_pkg::TAPS_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				fird_pkg::CFG_DECIMATION: dec_q  <= cfg_data[fird_pkg::DEC_W-1:0];
				fird_pkg::CFG_TAP_COUNT:  taps_q <= cfg_data[fird_pkg::TAPS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fird_pkg::ST_IDLE;
			phase_q     <= '0;
			wp_q        <= '0;
			rd_ptr_q    <= '0;
			k_q         <= '0;
			taps_run_q  <= '0;
			issue_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			issue_s1 <= issue;
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q & ~out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				fird_pkg::ST_IDLE: begin
					if (accept & ~is_load) begin
						wp_q <= wp_nxt;
						if (fire) begin
							phase_q    <= '0;
							rd_ptr_q   <= wp_nxt;
							k_q        <= '0;
							taps_run_q <= taps_eff;
							state_q    <= (taps_eff == '0) ? fird_pkg::ST_DRAIN
								: fird_pkg::ST_ISSUE;
						end else begin
							phase_q <= phase_inc[3:0];
						end
					end
				end
				fird_pkg::ST_ISSUE: begin
					k_q <= k_q + 1'b1;
					if (rd_ptr_q == '0) begin
						rd_ptr_q <= fird_pkg::ADDR_W'(fird_pkg::MAX_TAPS - 1);
					end else begin
						rd_ptr_q <= rd_ptr_q - 1'b1;
					end
					if (k_q + 1'b1 == taps_run_q) begin
						state_q <= fird_pkg::ST_DRAIN;
					end
				end
				fird_pkg::ST_DRAIN: begin
					if (done) begin
						state_q <= fird_pkg::ST_IDLE;
					end
				end
				default: state_q <= fird_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			filtered_q <= mac_result;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;

`ifndef SYNTHESIS
	a_out_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == fird_pkg::ST_DRAIN))
		else $error("result raised outside the drain step");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept & is_load) |=> !$rose(out_valid))
		else $error("coefficient load produced a result");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (k_q < taps_run_q))
		else $error("tap counter ran past the tap count");

	a_pipe_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fird_pkg::ST_IDLE) |-> (!issue_s1 && !mac_busy))
		else $error("MAC pipeline busy while idle");
`endif

endmodule

// File: tb/fir_decimator_checker.sv
// Checker for the decimating FIR filter: tracks state, predicts and compares output items.
module fir_decimator_checker
	import fird_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [CFG_DATA_W-1:0]          cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           command,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic [COEF_IDX_W-1:0]          coef_index,
	input  logic signed [SAMPLE_WIDTH-1:0] coef_value,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] filtered,
	output int                             fail_count,
	output int                             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [SAMPLE_WIDTH-1:0] coef_table [MAX_TAPS];
	logic signed [SAMPLE_WIDTH-1:0] sample_history [MAX_TAPS];
	logic signed [SAMPLE_WIDTH-1:0] expected_filtered [$];
	logic [DEC_W-1:0]               decimation;
	logic [TAPS_W-1:0]              tap_count;
	int                             phase;
	int                             mismatches;

	function automatic logic signed [SAMPLE_WIDTH-1:0] filter_output();
		longint acc;
		longint out_max;
		int     n;
		out_max = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
		n = (tap_count > MAX_TAPS) ? MAX_TAPS : int'(tap_count);
		acc = 0;
		for (int k = 0; k < n; k++) begin
			acc += longint'(coef_table[k]) * longint'(sample_history[k]);
		end
		acc = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (acc > out_max) begin
			acc = out_max;
		end else if (acc < -out_max - 1) begin
			acc = -out_max - 1;
		end
		return acc[SAMPLE_WIDTH-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int                             dec_eff;
		logic signed [SAMPLE_WIDTH-1:0] want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				coef_table[i]     = '0;
				sample_history[i] = '0;
			end
			expected_filtered.delete();
			decimation = DEC_W'(2);
			tap_count  = TAPS_W'(MAX_TAPS);
			phase      = 0;
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DECIMATION: decimation = cfg_data[DEC_W-1:0];
					CFG_TAP_COUNT:  tap_count  = cfg_data[TAPS_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_filtered.size() == 0) begin
					$error("filtered: no item expected, got %0d", filtered);
					mismatches++;
				end else begin
					want = expected_filtered.pop_front();
					if (filtered !== want) begin
						$error("filtered: expected %0d, got %0d", want, filtered);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (command == CMD_LOAD) begin
					coef_table[coef_index] = coef_value;
				end else begin
					for (int i = MAX_TAPS - 1; i > 0; i--) begin
						sample_history[i] = sample_history[i-1];
					end
					sample_history[0] = sample;
					if (decimation == 0) begin
						dec_eff = 1;
					end else if (decimation > MAX_DEC) begin
						dec_eff = MAX_DEC;
					end else begin
						dec_eff = int'(decimation);
					end
					if (phase + 1 < dec_eff) begin
						phase++;
					end else begin
						phase = 0;
						expected_filtered.push_back(filter_output());
					end
				end
			end
		end
		fail_count  <= mismatches;
		outstanding <= expected_filtered.size();
	end

endmodule

// File: tb/fir_decimator_tb.sv
// Testbench top of the decimating FIR filter: clock, reset, item stimulus, stall pattern and verdict.
module fir_decimator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fird_pkg::*;

	localparam int ITEM_TARGET    = 1800;
	localparam int DRAIN_CYCLES   = 80;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                           clk        = 1'b0;
	logic                           arst_n     = 1'b0;
	logic                           cfg_we     = 1'b0;
	logic                           cfg_index  = CFG_DECIMATION;
	logic [CFG_DATA_W-1:0]          cfg_data   = '0;
	logic                           in_valid   = 1'b0;
	logic                           in_stall;
	logic                           command    = CMD_SAMPLE;
	logic signed [SAMPLE_WIDTH-1:0] sample     = '0;
	logic [COEF_IDX_W-1:0]          coef_index = '0;
	logic signed [SAMPLE_WIDTH-1:0] coef_value = '0;
	logic                           out_valid;
	logic                           out_stall  = 1'b0;
	logic signed [SAMPLE_WIDTH-1:0] filtered;

	int fail_count;
	int outstanding;
	bit calm        = 1'b0;
	int stall_left  = 0;
	int idle_cycles = 0;
	int items_sent  = 0;

	fir_decimator u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.sample     (sample),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.filtered   (filtered)
	);

	fir_decimator_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.sample      (sample),
		.coef_index  (coef_index),
		.coef_value  (coef_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.filtered    (filtered),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		if (calm) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 2) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= ($urandom_range(0, 11) == 0) ? $urandom_range(20, 90)
			                                          : $urandom_range(0, 3);
		end else begin
			out_stall  <= 1'b0;
			stall_left <= $urandom_range(0, 8);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int gap_cycles();
		if (calm) begin
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			return $urandom_range(10, 60);
		end
		if ($urandom_range(0, 2) == 0) begin
			return $urandom_range(1, 3);
		end
		return 0;
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
		case ($urandom_range(0, 9))
			0: return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
			1: return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
			2: return SAMPLE_WIDTH'(int'($urandom_range(0, 64)) - 32);
			default: return SAMPLE_WIDTH'($urandom);
		endcase
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] random_coef(input int amp);
		if (amp >= 32767) begin
			return SAMPLE_WIDTH'($urandom);
		end
		return SAMPLE_WIDTH'(int'($urandom_range(0, 2 * amp)) - amp);
	endfunction

	task automatic issue(
		input logic                           cmd,
		input logic signed [SAMPLE_WIDTH-1:0] smp,
		input logic [COEF_IDX_W-1:0]          idx,
		input logic signed [SAMPLE_WIDTH-1:0] cval
	);
		int gap;
		in_valid   <= 1'b1;
		command    <= cmd;
		sample     <= smp;
		coef_index <= idx;
		coef_value <= cval;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		items_sent++;
		gap = gap_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] smp);
		issue(CMD_SAMPLE, smp, COEF_IDX_W'($urandom), SAMPLE_WIDTH'($urandom));
	endtask

	task automatic send_load(
		input logic [COEF_IDX_W-1:0]          idx,
		input logic signed [SAMPLE_WIDTH-1:0] cval
	);
		issue(CMD_LOAD, SAMPLE_WIDTH'($urandom), idx, cval);
	endtask

	task automatic wait_drained(input int extra);
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (extra) @(posedge clk);
	endtask

	task automatic apply_config(input logic [CFG_DATA_W-1:0] dec, input logic [CFG_DATA_W-1:0] taps);
		wait_drained(DRAIN_CYCLES);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DECIMATION;
		cfg_data  <= dec;
		@(posedge clk);
		cfg_index <= CFG_TAP_COUNT;
		cfg_data  <= taps;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		int                    phase_no;
		int                    phase_len;
		int                    amp;
		int                    taps_used;
		logic [CFG_DATA_W-1:0] dec_cfg;
		logic [CFG_DATA_W-1:0] taps_cfg;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// saturation both ways, rounding of exact halves, all-ones input
		send_load(6'd0, 16'sh8000);
		send_load(6'd1, 16'sh8000);
		send_load(6'd63, 16'sh7fff);
		send_sample(16'sh7fff);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		send_load(6'd1, 16'sh0000);
		send_load(6'd0, 16'sh0001);
		send_sample(16'sh0000);
		send_sample(16'sh4000);
		send_sample(16'sh0000);
		send_sample(16'shc000);
		send_load(6'd0, 16'sh7fff);
		send_sample(16'shffff);
		send_sample(16'shffff);

		phase_no = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase_no)
				0: begin dec_cfg = 7'd1;   taps_cfg = 7'd64;  end
				1: begin dec_cfg = 7'd16;  taps_cfg = 7'd64;  end
				2: begin dec_cfg = 7'd0;   taps_cfg = 7'd0;   end
				3: begin dec_cfg = 7'd31;  taps_cfg = 7'd127; end
				4: begin dec_cfg = 7'd3;   taps_cfg = 7'd1;   end
				5: begin dec_cfg = 7'h62;  taps_cfg = 7'd65;  end
				6: begin dec_cfg = 7'd5;   taps_cfg = 7'd17;  end
				7: begin dec_cfg = 7'd2;   taps_cfg = 7'd63;  end
				default: begin
					dec_cfg  = ($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom)
					                                       : CFG_DATA_W'($urandom_range(1, 6));
					taps_cfg = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom)
					                                       : CFG_DATA_W'($urandom_range(1, 16));
				end
			endcase
			apply_config(dec_cfg, taps_cfg);
			calm <= ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 2))
				0: amp = 32767;
				1: amp = 4095;
				default: amp = 255;
			endcase
			taps_used = (taps_cfg > MAX_TAPS) ? MAX_TAPS : int'(taps_cfg);
			for (int k = 0; k < taps_used; k++) begin
				if ($urandom_range(0, 3) != 0) begin
					send_load(COEF_IDX_W'(k), random_coef(amp));
				end
			end
			phase_len = $urandom_range(80, 160);
			for (int i = 0; i < phase_len; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					send_load(COEF_IDX_W'($urandom), random_coef(amp));
				end else begin
					send_sample(random_sample());
				end
				if ($urandom_range(0, 99) == 0) begin
					wait_drained(0);
				end
			end
			phase_no++;
		end

		wait_drained(DRAIN_CYCLES);
		if (fail_count == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/fird_pkg.sv
rtl/core/fird_store.sv
rtl/core/fird_mac.sv
rtl/core/fir_decimator.sv
tb/fir_decimator_checker.sv
tb/fir_decimator_tb.sv
